// ----- hdl/kmnc_pkg.sv -----
// Shared types and constants for the nearest-centroid classifier.
// No dependencies; imported by kmnc_cell and kmeans_nearest_centroid.
package kmnc_pkg;

  // Configuration register indexes
  localparam logic CFG_NORM_MODE       = 1'b0;
  localparam logic CFG_ACTIVE_CLUSTERS = 1'b1;

  // Distance kinds; any other code selects squared Euclidean
  localparam logic [1:0] NORM_CHEB = 2'd0;
  localparam logic [1:0] NORM_L1   = 2'd1;
  localparam logic [1:0] NORM_L2SQ = 2'd2;

  localparam int unsigned LABEL_W  = 3;
  localparam int unsigned DIST_W   = 34;
  localparam int unsigned OUT_W    = 40;
  localparam int unsigned CFG_W    = 4;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Item kinds
  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  // Control that travels with each item along the chain
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [LABEL_W-1:0] slot;
  } ctl_t;

endpackage

// ----- hdl/kmeans_nearest_centroid.sv -----
// Nearest-centroid classifier for k-means: a chain of CLUSTERS centroid cells,
// each two register stages deep, followed by an output register. Uses kmnc_pkg
// and kmnc_cell. Centroid writes (tuser 0) and points (tuser 1) flow down the
// same chain, so a write takes effect for every later point and none earlier.
// One item enters per cycle while the output side keeps up; a point's result
// is registered through both stages of every cell and then the output register.
// A stall on out_tready freezes the whole chain. Slots never written read
// back as undefined; classify only after the active centroids are loaded.
module kmeans_nearest_centroid #(
  parameter int CLUSTERS   = 8,
  parameter int DIMS       = 4,
  parameter int COORD_BITS = 16,
  localparam int IN_W = ((kmnc_pkg::LABEL_W + DIMS * COORD_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [kmnc_pkg::CFG_W-1:0]  cfg_wdata,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_W-1:0]             in_tdata,  // cluster_index, coord_0 .. coord_N, zero pad
  input  logic                        in_tuser,  // kind
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [kmnc_pkg::OUT_W-1:0]  out_tdata  // nearest_label, nearest_distance, zero pad
);
  import kmnc_pkg::*;

  localparam int MAG_W = COORD_BITS + 1;
  localparam int ACC_W = 2 * MAG_W + $clog2(DIMS) + 1;
  localparam int LBL_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int EXT_W = (ACC_W > DIST_W) ? ACC_W : DIST_W + 1;

  logic [1:0]       norm_r;
  logic [CFG_W-1:0] active_r;

  ctl_t                            ctl_c [CLUSTERS+1];
  logic [DIMS-1:0][COORD_BITS-1:0] pt_c  [CLUSTERS+1];
  logic [ACC_W-1:0]                bd_c  [CLUSTERS+1];
  logic [LBL_W-1:0]                bl_c  [CLUSTERS+1];
  logic [CLUSTERS-1:0]             cell_act;

  logic                 en;
  logic                 out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0]   out_label_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic [EXT_W-1:0]     dist_ext;
  logic [LBL_W+LABEL_W-1:0] label_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r   <= NORM_L2SQ;
      active_r <= CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NORM_MODE:       norm_r   <= cfg_wdata[1:0];
        CFG_ACTIVE_CLUSTERS: active_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold the chain while a result waits
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    ctl_c[0].valid = in_tvalid;
    ctl_c[0].kind  = in_tuser;
    ctl_c[0].slot  = in_tdata[LABEL_W-1:0];
    for (int i = 0; i < DIMS; i++) begin
      pt_c[0][i] = in_tdata[LABEL_W + i*COORD_BITS +: COORD_BITS];
    end
    bd_c[0] = '1;
    bl_c[0] = '0;
  end

  // at least two centroids always take part
  always_comb begin
    for (int j = 0; j < CLUSTERS; j++) begin
      cell_act[j] = (j < 2) || (32'(j) < 32'(active_r));
    end
  end

  for (genvar j = 0; j < CLUSTERS; j++) begin : g_chain
    kmnc_cell #(
      .CELL_IDX   (j),
      .DIMS       (DIMS),
      .COORD_BITS (COORD_BITS),
      .LBL_W      (LBL_W),
      .ACC_W      (ACC_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .active    (cell_act[j]),
      .norm_mode (norm_r),
      .ctl_i     (ctl_c[j]),
      .pt_i      (pt_c[j]),
      .best_d_i  (bd_c[j]),
      .best_l_i  (bl_c[j]),
      .ctl_o     (ctl_c[j+1]),
      .pt_o      (pt_c[j+1]),
      .best_d_o  (bd_c[j+1]),
      .best_l_o  (bl_c[j+1])
    );
  end

  // drop centroid writes at the end of the chain
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = ctl_c[CLUSTERS].valid && (ctl_c[CLUSTERS].kind == KIND_CLASSIFY);
    end
  end

  assign dist_ext  = EXT_W'(bd_c[CLUSTERS]);
  assign label_ext = {{LABEL_W{1'b0}}, bl_c[CLUSTERS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_label_r <= label_ext[LABEL_W-1:0];
      out_dist_r  <= (dist_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - LABEL_W - DIST_W){1'b0}}, out_dist_r, out_label_r};

endmodule

// ----- hdl/kmnc_cell.sv -----
// One centroid cell of the classifier chain: holds a centroid, measures the
// passing point against it and keeps the running best. Uses kmnc_pkg.
module kmnc_cell #(
  parameter int CELL_IDX   = 0,
  parameter int DIMS       = 4,
  parameter int COORD_BITS = 16,
  parameter int LBL_W      = 3,
  parameter int ACC_W      = 37
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 active,
  input  logic [1:0]                           norm_mode,
  input  kmnc_pkg::ctl_t                       ctl_i,
  input  logic [DIMS-1:0][COORD_BITS-1:0]      pt_i,
  input  logic [ACC_W-1:0]                     best_d_i,
  input  logic [LBL_W-1:0]                     best_l_i,
  output kmnc_pkg::ctl_t                       ctl_o,
  output logic [DIMS-1:0][COORD_BITS-1:0]      pt_o,
  output logic [ACC_W-1:0]                     best_d_o,
  output logic [LBL_W-1:0]                     best_l_o
);
  import kmnc_pkg::*;

  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;

  logic [DIMS-1:0][COORD_BITS-1:0] cen_r;

  // stage A: per-dimension magnitudes and squares
  ctl_t                             a_ctl_r, a_ctl_nxt;
  logic [DIMS-1:0][COORD_BITS-1:0]  a_pt_r;
  logic [DIMS-1:0][MAG_W-1:0]       a_mag_r, a_mag_nxt;
  logic [DIMS-1:0][SQ_W-1:0]        a_sq_r, a_sq_nxt;
  logic [ACC_W-1:0]                 a_bd_r;
  logic [LBL_W-1:0]                 a_bl_r;

  // stage B: reduce and compare
  ctl_t                             b_ctl_r, b_ctl_nxt;
  logic [DIMS-1:0][COORD_BITS-1:0]  b_pt_r;
  logic [ACC_W-1:0]                 b_bd_r, b_bd_nxt;
  logic [LBL_W-1:0]                 b_bl_r, b_bl_nxt;

  logic                             wr_hit;
  logic [ACC_W-1:0]                 cur_dist;

  assign wr_hit = ctl_i.valid && (ctl_i.kind == KIND_WRITE) &&
                  (32'(ctl_i.slot) == 32'(CELL_IDX));

  always_comb begin
    logic signed [MAG_W-1:0] d;
    a_ctl_nxt = ctl_i;
    for (int i = 0; i < DIMS; i++) begin
      d = $signed({pt_i[i][COORD_BITS-1], pt_i[i]}) -
          $signed({cen_r[i][COORD_BITS-1], cen_r[i]});
      a_mag_nxt[i] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
      a_sq_nxt[i]  = SQ_W'(a_mag_nxt[i]) * SQ_W'(a_mag_nxt[i]);
    end
  end

  always_comb begin
    cur_dist = '0;
    case (norm_mode)
      NORM_CHEB: begin
        for (int i = 0; i < DIMS; i++) begin
          if (ACC_W'(a_mag_r[i]) > cur_dist) begin
            cur_dist = ACC_W'(a_mag_r[i]);
          end
        end
      end
      NORM_L1: begin
        for (int i = 0; i < DIMS; i++) begin
          cur_dist = cur_dist + ACC_W'(a_mag_r[i]);
        end
      end
      default: begin
        for (int i = 0; i < DIMS; i++) begin
          cur_dist = cur_dist + ACC_W'(a_sq_r[i]);
        end
      end
    endcase
  end

  // strict compare keeps the lowest index on ties
  always_comb begin
    b_ctl_nxt = a_ctl_r;
    b_bd_nxt  = a_bd_r;
    b_bl_nxt  = a_bl_r;
    if (active && (cur_dist < a_bd_r)) begin
      b_bd_nxt = cur_dist;
      b_bl_nxt = LBL_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
    end else if (en) begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= b_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_hit) begin
        cen_r <= pt_i;
      end
      a_pt_r  <= pt_i;
      a_mag_r <= a_mag_nxt;
      a_sq_r  <= a_sq_nxt;
      a_bd_r  <= best_d_i;
      a_bl_r  <= best_l_i;
      b_pt_r  <= a_pt_r;
      b_bd_r  <= b_bd_nxt;
      b_bl_r  <= b_bl_nxt;
    end
  end

  assign ctl_o    = b_ctl_r;
  assign pt_o     = b_pt_r;
  assign best_d_o = b_bd_r;
  assign best_l_o = b_bl_r;

endmodule
